FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/sha1md_pkg.sv
package sha1md_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [4:0][31:0] chain_type;

   localparam int unsigned NUM_WORDS = 5;

   localparam logic [2:0]  CSR_LIMIT     = 3'(NUM_WORDS);
   localparam logic [2:0]  LAST_WORD_IDX = 3'(NUM_WORDS - 1);

   localparam logic [6:0]  BLOCK_BYTES = 7'd64;
   localparam logic [6:0]  LEN_FILL    = 7'd56;
   localparam logic [6:0]  LAST_ROUND  = 7'd79;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   localparam word_type    ROUND_K0 = 32'h5a827999;
   localparam word_type    ROUND_K1 = 32'h6ed9eba1;
   localparam word_type    ROUND_K2 = 32'h8f1bbcdc;
   localparam word_type    ROUND_K3 = 32'hca62c1d6;

   localparam chain_type   INIT_CHAIN = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                         32'hefcdab89, 32'h67452301};

   typedef struct packed {
      logic load;
      logic step;
   } round_ctrl_type;

   typedef struct packed {
      logic final_round;
   } round_stat_type;

endpackage

FILE: src/sha1md_if.sv
interface sha1md_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last;

   modport source (output valid, output data_word, output valid_bytes, output last,
                   input ready);
   modport sink   (input valid, input data_word, input valid_bytes, input last,
                   output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);
endinterface

interface sha1md_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/sha1md_round.sv
`include "assert_macros.svh"

module sha1md_round import sha1md_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  chain_type      chain,
   input  word_type       w,
   output chain_type      regs,
   output round_stat_type stat
);

   logic [6:0] round_count_ff;
   logic [6:0] round_count_in;
   chain_type  regs_ff;
   chain_type  regs_in;
   word_type   f;
   word_type   k;
   word_type   t;

   always_comb begin
      if (round_count_ff < 7'd20) begin
         f = regs_ff[3] ^ (regs_ff[1] & (regs_ff[2] ^ regs_ff[3]));
         k = ROUND_K0;
      end else if (round_count_ff < 7'd40) begin
         f = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
         k = ROUND_K1;
      end else if (round_count_ff < 7'd60) begin
         f = (regs_ff[1] & regs_ff[2]) | (regs_ff[3] & (regs_ff[1] | regs_ff[2]));
         k = ROUND_K2;
      end else begin
         f = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
         k = ROUND_K3;
      end
      t = {regs_ff[0][26:0], regs_ff[0][31:27]} + f + regs_ff[4] + w + k;
   end

   always_comb begin
      regs_in        = regs_ff;
      round_count_in = round_count_ff;
      if (ctrl.load) begin
         regs_in        = chain;
         round_count_in = 7'd0;
      end else if (ctrl.step) begin
         regs_in[4] = regs_ff[3];
         regs_in[3] = regs_ff[2];
         regs_in[2] = {regs_ff[1][1:0], regs_ff[1][31:2]};
         regs_in[1] = regs_ff[0];
         regs_in[0] = t;
         round_count_in = (round_count_ff == LAST_ROUND) ? 7'd0 : round_count_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= 7'd0;
      end else begin
         round_count_ff <= round_count_in;
      end
   end

   always_ff @(posedge clock) begin
      regs_ff <= regs_in;
   end

   assign regs             = regs_ff;
   assign stat.final_round = (round_count_ff == LAST_ROUND);

   `CHECK_ALWAYS(a_count_range, clock, reset, round_count_ff <= LAST_ROUND)
   `CHECK_ALWAYS(a_ctrl_excl, clock, reset, !(ctrl.load && ctrl.step))
   `CHECK_NEXT(a_load_clears, clock, reset, ctrl.load, round_count_ff == 7'd0)

endmodule

FILE: src/sha1_message_digest.sv
// SHA-1 digest of a byte stream.
// req_if : message items, data_word with earliest byte in bits 31:24, valid_bytes
//          (values above four count as four) and last on the final item.
// rsp_if : five digest words, word_index 0 first, last_word on index 4.
// csr_if : writes init_word_a..e at index 0..4; other indexes are ignored. The
//          values are taken at the first item of the next message. Always ready.
// Flow: a full word at a 4-byte aligned fill position that is not the last
// item is written straight into the block buffer on acceptance. Any other item
// is unpacked byte by byte, or as one word if it is a full last word at an
// aligned position, while req_if.ready is low. Each 64-byte block then runs
// 80 rounds on a single shared round unit plus one chaining add, during which
// req_if.ready is low, so no new item is taken until the block is done. After
// the last item the pad byte and zero fill are written, one or two block
// compressions follow, and the five result words come out one per accepted
// handshake.
// Reset clears the message state and restores the standard initial values.
// While rsp_if.ready is low the current result word holds and no item is taken.
`include "assert_macros.svh"

module sha1_message_digest import sha1md_pkg::*; (
   input logic         clock,
   input logic         reset,
   sha1md_req_if.sink   req_if,
   sha1md_rsp_if.source rsp_if,
   sha1md_csr_if.sink   csr_if
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PACK  = 7'b0000010,
      S_PAD   = 7'b0000100,
      S_ZERO  = 7'b0001000,
      S_ROUND = 7'b0010000,
      S_ADD   = 7'b0100000,
      S_SEND  = 7'b1000000
   } state_type;

   state_type      state_ff, state_in;
   state_type      ret_ff, ret_in;
   logic           final_ff, final_in;
   logic           active_ff, active_in;
   logic [6:0]     fill_ff, fill_in;
   logic [63:0]    bitlen_ff, bitlen_in;
   word_type       hold_ff, hold_in;
   logic [2:0]     rem_ff, rem_in;
   logic           last_ff, last_in;
   logic [2:0]     idx_ff, idx_in;
   chain_type      init_ff;
   chain_type      chain_ff, chain_in;
   word_type       buf_ff [16];

   logic           req_accept;
   logic           rsp_accept;
   logic [2:0]     nb_c;
   logic           fast;
   logic [6:0]     fill_nx;
   logic           start_blk;
   logic           blk_final;
   state_type      blk_ret;
   logic           wr_en;
   logic [3:0]     wr_addr;
   word_type       wr_data;
   word_type       byte_merged;
   logic [7:0]     byte_val;
   logic [4:0]     byte_sh;
   logic           len_we;
   logic           shift_en;
   word_type       sched_new;
   round_ctrl_type rctrl;
   round_stat_type rstat;
   chain_type      rregs;

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_accept = rsp_if.valid && rsp_if.ready;
   assign nb_c       = (req_if.valid_bytes > 3'd4) ? 3'd4 : req_if.valid_bytes;
   assign fast       = (fill_ff[1:0] == 2'b00) && (nb_c == 3'd4) && !req_if.last;

   assign byte_val    = (state_ff == S_PAD) ? PAD_BYTE : hold_ff[31:24];
   assign byte_sh     = {~fill_ff[1:0], 3'b000};
   assign byte_merged = ((fill_ff[1:0] == 2'b00) ? 32'd0 : buf_ff[fill_ff[5:2]])
                        | ({24'd0, byte_val} << byte_sh);
   assign sched_new   = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      final_in  = final_ff;
      active_in = active_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      hold_in   = hold_ff;
      rem_in    = rem_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      chain_in  = chain_ff;
      fill_nx   = fill_ff;
      start_blk = 1'b0;
      blk_final = 1'b0;
      blk_ret   = S_IDLE;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[5:2];
      wr_data   = byte_merged;
      len_we    = 1'b0;
      shift_en  = 1'b0;
      rctrl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (!active_ff) begin
                  chain_in = init_ff;
               end
               active_in = 1'b1;
               bitlen_in = bitlen_ff + {58'd0, nb_c, 3'b000};
               if (fast) begin
                  wr_en   = 1'b1;
                  wr_data = req_if.data_word;
                  fill_nx = fill_ff + 7'd4;
                  if (fill_nx == BLOCK_BYTES) begin
                     fill_in   = 7'd0;
                     start_blk = 1'b1;
                     blk_ret   = S_IDLE;
                  end else begin
                     fill_in = fill_nx;
                  end
               end else begin
                  hold_in  = req_if.data_word;
                  rem_in   = nb_c;
                  last_in  = req_if.last;
                  state_in = S_PACK;
               end
            end
         end
         S_PACK: begin
            if (rem_ff == 3'd0) begin
               state_in = last_ff ? S_PAD : S_IDLE;
            end else begin
               wr_en = 1'b1;
               if ((fill_ff[1:0] == 2'b00) && (rem_ff == 3'd4)) begin
                  wr_data = hold_ff;
                  rem_in  = 3'd0;
                  fill_nx = fill_ff + 7'd4;
               end else begin
                  hold_in = {hold_ff[23:0], 8'd0};
                  rem_in  = rem_ff - 3'd1;
                  fill_nx = fill_ff + 7'd1;
               end
               if (fill_nx == BLOCK_BYTES) begin
                  fill_in   = 7'd0;
                  start_blk = 1'b1;
                  blk_ret   = S_PACK;
               end else begin
                  fill_in = fill_nx;
               end
            end
         end
         S_PAD: begin
            wr_en   = 1'b1;
            fill_nx = {fill_ff[6:2] + 5'd1, 2'b00};
            if (fill_nx == BLOCK_BYTES) begin
               fill_in   = 7'd0;
               start_blk = 1'b1;
               blk_ret   = S_ZERO;
            end else begin
               fill_in  = fill_nx;
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (fill_ff == LEN_FILL) begin
               len_we    = 1'b1;
               fill_in   = 7'd0;
               start_blk = 1'b1;
               blk_final = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_data = 32'd0;
               fill_nx = fill_ff + 7'd4;
               if (fill_nx == BLOCK_BYTES) begin
                  fill_in   = 7'd0;
                  start_blk = 1'b1;
                  blk_ret   = S_ZERO;
               end else begin
                  fill_in = fill_nx;
               end
            end
         end
         S_ROUND: begin
            rctrl.step = 1'b1;
            shift_en   = 1'b1;
            if (rstat.final_round) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int j = 0; j < NUM_WORDS; j++) begin
               chain_in[j] = chain_ff[j] + rregs[j];
            end
            idx_in   = 3'd0;
            state_in = final_ff ? S_SEND : ret_ff;
         end
         S_SEND: begin
            if (rsp_accept) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  idx_in    = 3'd0;
                  active_in = 1'b0;
                  bitlen_in = 64'd0;
                  state_in  = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (start_blk) begin
         rctrl.load = 1'b1;
         state_in   = S_ROUND;
         ret_in     = blk_ret;
         final_in   = blk_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         final_ff  <= 1'b0;
         active_ff <= 1'b0;
         fill_ff   <= 7'd0;
         bitlen_ff <= 64'd0;
         rem_ff    <= 3'd0;
         last_ff   <= 1'b0;
         idx_ff    <= 3'd0;
         chain_ff  <= INIT_CHAIN;
         init_ff   <= INIT_CHAIN;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         final_ff  <= final_in;
         active_ff <= active_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
         rem_ff    <= rem_in;
         last_ff   <= last_in;
         idx_ff    <= idx_in;
         chain_ff  <= chain_in;
         if (csr_if.valid && csr_if.ready && (csr_if.index < CSR_LIMIT)) begin
            init_ff[csr_if.index] <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // block buffer doubles as the message schedule shift line during the rounds
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
         buf_ff[15] <= {sched_new[30:0], sched_new[31]};
      end else if (len_we) begin
         buf_ff[14] <= bitlen_ff[63:32];
         buf_ff[15] <= bitlen_ff[31:0];
      end else if (wr_en) begin
         buf_ff[wr_addr] <= wr_data;
      end
   end

   sha1md_round u_round (
      .clock (clock),
      .reset (reset),
      .ctrl  (rctrl),
      .chain (chain_ff),
      .w     (buf_ff[0]),
      .regs  (rregs),
      .stat  (rstat)
   );

   assign req_if.ready       = (state_ff == S_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = (state_ff == S_SEND);
   assign rsp_if.digest_word = chain_ff[idx_ff];
   assign rsp_if.word_index  = idx_ff;
   assign rsp_if.last_word   = (idx_ff == LAST_WORD_IDX);

   `CHECK_ALWAYS(a_rsp_blocks_req, clock, reset, !(rsp_if.valid && req_if.ready))
   `CHECK_ALWAYS(a_fill_range, clock, reset, fill_ff < BLOCK_BYTES)
   `CHECK_NEXT(a_send_advance, clock, reset, rsp_accept && !rsp_if.last_word, rsp_if.valid)

endmodule
